// ----- rtl/icv_pkg.sv -----
// ----------------------------------------------------------------------------
// icv_pkg: shared types and constants for the 3x3 convolution unit
// Pixel, column and window types, the result item, register indexes and the
// fixed arithmetic widths of the multiply/accumulate pipeline.
// ----------------------------------------------------------------------------
package icv_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int SIZE_W     = 11;
  localparam int SIZE_RESET = 1024;

  localparam logic [CFG_DATA_W-1:0] COEF_TOP_RESET = 48'h0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] COEF_MID_RESET = 48'h0000_1000_0000;
  localparam logic [CFG_DATA_W-1:0] COEF_BOT_RESET = 48'h0000_0000_0000;

  localparam logic CMD_DRAIN = 1'b1;

  localparam int COEF_W     = 16;
  localparam int PROD_W     = 25;
  localparam int PSUM_W     = 27;
  localparam int SUM_W      = 29;
  localparam int FRAC_BITS  = 12;
  localparam int ROUND_HALF = 2048;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOTTOM  = 3'd4
  } cfg_reg_t;

  typedef logic [7:0] pixel_t;

  // one column of the neighborhood: rows y-1, y, y+1 (already clamped)
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    column_t left;
    column_t center;
    column_t right;
  } window_t;

  // line store entry: the two most recent rows of one column
  typedef struct packed {
    pixel_t newer;
    pixel_t older;
  } line_ent_t;

  typedef struct packed {
    logic row_last;
    logic frame_last;
  } pos_flags_t;

  typedef struct packed {
    pixel_t pixel;
    logic   row_last;
    logic   frame_last;
  } out_item_t;

  // control carried from the accept stage into the line store read stage
  typedef struct packed {
    logic valid;
    logic pix;
    logic row0;
    logic out_due;
    logic col0;
    logic left_v1;
    logic row_last;
    logic frame_last;
  } s1_ctl_t;

endpackage

// ----- rtl/icv_mac.sv -----
// ----------------------------------------------------------------------------
// icv_mac: 3x3 multiply/accumulate with rounding and saturation
// Three register stages: nine products, three row sums, final sum rounded
// half up, shifted by the Q4.12 fraction and clipped to 0..255.
// ----------------------------------------------------------------------------
module icv_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                win_valid,
  input  icv_pkg::window_t                    win,
  input  icv_pkg::pos_flags_t                 win_flags,
  input  logic [icv_pkg::CFG_DATA_W-1:0]      coeff_row_top,
  input  logic [icv_pkg::CFG_DATA_W-1:0]      coeff_row_mid,
  input  logic [icv_pkg::CFG_DATA_W-1:0]      coeff_row_bottom,
  output logic                                res_valid,
  output icv_pkg::out_item_t                  res
);
  import icv_pkg::*;

  pixel_t                    pix [9];
  logic signed [COEF_W-1:0]  kern [9];

  logic signed [PROD_W-1:0]  prod_nxt [9];
  logic signed [PROD_W-1:0]  prod_r   [9];
  logic                      prod_valid_r;
  pos_flags_t                prod_flags_r;

  logic signed [PSUM_W-1:0]  psum_nxt [3];
  logic signed [PSUM_W-1:0]  psum_r   [3];
  logic                      psum_valid_r;
  pos_flags_t                psum_flags_r;

  logic signed [SUM_W-1:0]   sum_nxt;
  pixel_t                    sat_nxt;
  logic                      res_valid_r;
  out_item_t                 res_r;

  // window in dy*3+dx order; kernel is applied flipped
  always_comb begin
    pix[0] = win.left.top;
    pix[1] = win.center.top;
    pix[2] = win.right.top;
    pix[3] = win.left.mid;
    pix[4] = win.center.mid;
    pix[5] = win.right.mid;
    pix[6] = win.left.bot;
    pix[7] = win.center.bot;
    pix[8] = win.right.bot;
    for (int j = 0; j < 3; j++) begin
      kern[j]     = coeff_row_top[COEF_W*j +: COEF_W];
      kern[j + 3] = coeff_row_mid[COEF_W*j +: COEF_W];
      kern[j + 6] = coeff_row_bottom[COEF_W*j +: COEF_W];
    end
    for (int i = 0; i < 9; i++) begin
      prod_nxt[i] = $signed({1'b0, pix[i]}) * kern[8 - i];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      psum_nxt[r] = PSUM_W'(prod_r[3*r]) + PSUM_W'(prod_r[3*r + 1])
                  + PSUM_W'(prod_r[3*r + 2]);
    end
  end

  always_comb begin
    sum_nxt = SUM_W'(psum_r[0]) + SUM_W'(psum_r[1]) + SUM_W'(psum_r[2])
            + SUM_W'(ROUND_HALF);
    if (sum_nxt[SUM_W-1]) begin
      sat_nxt = 8'd0;
    end else if (|sum_nxt[SUM_W-2:FRAC_BITS+8]) begin
      sat_nxt = 8'd255;
    end else begin
      sat_nxt = sum_nxt[FRAC_BITS+7:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      psum_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      prod_valid_r <= win_valid;
      psum_valid_r <= prod_valid_r;
      res_valid_r  <= psum_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    prod_flags_r <= win_flags;
    psum_r       <= psum_nxt;
    psum_flags_r <= prod_flags_r;
    res_r.pixel      <= sat_nxt;
    res_r.row_last   <= psum_flags_r.row_last;
    res_r.frame_last <= psum_flags_r.frame_last;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ----- rtl/image_convolution_3x3_unit.sv -----
// ----------------------------------------------------------------------------
// image_convolution_3x3_unit: streaming 3x3 convolution, replicated borders
//
//   channel | dir | ports                                   | transfer when
//   --------+-----+-----------------------------------------+-------------------
//   in      | in  | in_valid in_stall in_cmd in_pixel_in    | valid & !stall
//   out     | out | out_valid out_stall out_pixel_out       | valid & !stall
//           |     | out_row_last out_frame_last             |
//   cfg     | in  | cfg_wr_en cfg_index cfg_wdata           | wr_en
//
// One item per clock while in_stall is low. A result leaves the 4-stage
// pipeline (line store read, products, row sums, round/clip) into an 8-entry
// output queue. in_stall is high during reset and when 8 results are
// outstanding. Reset is synchronous; the line store needs no clearing pass.
// ----------------------------------------------------------------------------
module image_convolution_3x3_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  icv_pkg::pixel_t                    in_pixel_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output icv_pkg::pixel_t                    out_pixel_out,
  output logic                               out_row_last,
  output logic                               out_frame_last,
  input  logic                               cfg_wr_en,
  input  logic [icv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [icv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import icv_pkg::*;

  localparam int COLW    = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int ROWW    = $clog2(MAX_HEIGHT + 2);
  localparam int W_RESET = (MAX_WIDTH < SIZE_RESET) ? MAX_WIDTH : SIZE_RESET;
  localparam int H_RESET = (MAX_HEIGHT < SIZE_RESET) ? MAX_HEIGHT : SIZE_RESET;

  // configuration
  logic [WW-1:0]         w_eff_r, w_cfg_nxt;
  logic [ROWW-1:0]       h_eff_r, h_cfg_nxt;
  logic [CFG_DATA_W-1:0] coef_top_r, coef_mid_r, coef_bot_r;
  logic [SIZE_W-1:0]     cfg_size;
  logic                  restart;

  // accept stage
  logic [COLW-1:0]       in_column_r, in_column_nxt;
  logic [ROWW-1:0]       in_row_r, in_row_nxt;
  logic [WW-1:0]         col_inc;
  logic                  acc, eff, pix_phase, col0, out_due, row_last, frame_last;
  s1_ctl_t               s1_r, s1_nxt;
  pixel_t                s1_px_r;
  logic [COLW-1:0]       s1_addr_r;

  // line store
  line_ent_t             line_mem [MAX_WIDTH];
  line_ent_t             rd_data_r;
  logic                  wb_valid_r;
  logic [COLW-1:0]       wb_addr_r;
  line_ent_t             wb_data_r, wb_data_nxt, ent;
  logic                  wb_en;

  // column history and window
  column_t               vec, v1_r, v2_r;
  window_t               win;
  pos_flags_t            win_flags;

  // result queue
  logic                  res_valid;
  out_item_t             res;
  out_item_t             fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt, cred_r, cred_nxt;
  logic                  out_xfer;

  // ---------------------------------------------------------------- config
  assign cfg_size = cfg_wdata[SIZE_W-1:0];

  always_comb begin
    if (cfg_size == '0) begin
      w_cfg_nxt = WW'(1);
      h_cfg_nxt = ROWW'(1);
    end else begin
      w_cfg_nxt = (32'(cfg_size) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)    : WW'(cfg_size);
      h_cfg_nxt = (32'(cfg_size) > 32'(MAX_HEIGHT)) ? ROWW'(MAX_HEIGHT) : ROWW'(cfg_size);
    end
  end

  assign restart = cfg_wr_en &&
                   (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r    <= WW'(W_RESET);
      h_eff_r    <= ROWW'(H_RESET);
      coef_top_r <= COEF_TOP_RESET;
      coef_mid_r <= COEF_MID_RESET;
      coef_bot_r <= COEF_BOT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  w_eff_r    <= w_cfg_nxt;
        REG_IMAGE_HEIGHT: h_eff_r    <= h_cfg_nxt;
        REG_COEF_TOP:     coef_top_r <= cfg_wdata;
        REG_COEF_MID:     coef_mid_r <= cfg_wdata;
        REG_COEF_BOTTOM:  coef_bot_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- accept stage
  assign in_stall = !rst_n || (cred_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign acc      = in_valid && !in_stall;

  // an item is a pixel until the frame is in; after that it is a drain tick
  assign pix_phase  = in_row_r < h_eff_r;
  assign eff        = acc && !(pix_phase && in_cmd == CMD_DRAIN);
  assign col0       = in_column_r == '0;
  // output trails input by one row and one pixel
  assign out_due    = (in_row_r >= ROWW'(2)) || (in_row_r == ROWW'(1) && !col0);
  // the pixel ending an output row is produced by a column-0 item
  assign row_last   = out_due && col0;
  assign frame_last = row_last && (in_row_r == h_eff_r + ROWW'(1));
  assign col_inc    = WW'(in_column_r) + WW'(1);

  always_comb begin
    in_column_nxt = in_column_r;
    in_row_nxt    = in_row_r;
    if (restart) begin
      in_column_nxt = '0;
      in_row_nxt    = '0;
    end else if (eff) begin
      if (frame_last) begin
        in_column_nxt = '0;
        in_row_nxt    = '0;
      end else if (col_inc >= w_eff_r) begin
        in_column_nxt = '0;
        in_row_nxt    = in_row_r + ROWW'(1);
      end else begin
        in_column_nxt = COLW'(col_inc);
      end
    end
  end

  always_comb begin
    s1_nxt.valid      = eff;
    s1_nxt.pix        = pix_phase;
    s1_nxt.row0       = in_row_r == '0;
    s1_nxt.out_due    = out_due;
    s1_nxt.col0       = col0;
    s1_nxt.left_v1    = col0 ? (w_eff_r == WW'(1)) : (in_column_r == COLW'(1));
    s1_nxt.row_last   = row_last;
    s1_nxt.frame_last = frame_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_column_r <= '0;
      in_row_r    <= '0;
      s1_r        <= '0;
    end else begin
      in_column_r <= in_column_nxt;
      in_row_r    <= in_row_nxt;
      s1_r        <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_px_r   <= in_pixel_in;
    s1_addr_r <= in_column_r;
  end

  // ------------------------------------------------------------ line store
  always_ff @(posedge clk) begin
    rd_data_r <= line_mem[in_column_r];
    if (wb_en) begin
      line_mem[s1_addr_r] <= wb_data_nxt;
    end
  end

  // a write at the edge that also read the same entry is forwarded
  assign ent = (wb_valid_r && wb_addr_r == s1_addr_r) ? wb_data_r : rd_data_r;

  always_comb begin
    vec.top = ent.older;
    vec.mid = ent.newer;
    vec.bot = s1_r.pix ? s1_px_r : ent.newer;
    wb_en             = s1_r.valid && s1_r.pix;
    wb_data_nxt.newer = s1_px_r;
    // first row stands in for the missing row above it
    wb_data_nxt.older = s1_r.row0 ? s1_px_r : ent.newer;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else begin
      wb_valid_r <= wb_en;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= s1_addr_r;
    wb_data_r <= wb_data_nxt;
    if (s1_r.valid) begin
      v2_r <= v1_r;
      v1_r <= vec;
    end
  end

  // right edge repeats the last column, left edge the first
  always_comb begin
    win.right  = s1_r.col0 ? v1_r : vec;
    win.center = v1_r;
    win.left   = s1_r.left_v1 ? v1_r : v2_r;
    win_flags.row_last   = s1_r.row_last;
    win_flags.frame_last = s1_r.frame_last;
  end

  icv_mac u_mac (
    .clk              (clk),
    .rst_n            (rst_n),
    .win_valid        (s1_r.valid && s1_r.out_due),
    .win              (win),
    .win_flags        (win_flags),
    .coeff_row_top    (coef_top_r),
    .coeff_row_mid    (coef_mid_r),
    .coeff_row_bottom (coef_bot_r),
    .res_valid        (res_valid),
    .res              (res)
  );

  // ---------------------------------------------------------- result queue
  assign out_valid      = cnt_r != '0;
  assign out_xfer       = out_valid && !out_stall;
  assign out_pixel_out  = fifo_mem[rd_ptr_r].pixel;
  assign out_row_last   = fifo_mem[rd_ptr_r].row_last;
  assign out_frame_last = fifo_mem[rd_ptr_r].frame_last;

  // credits: results accepted but not yet transferred out
  always_comb begin
    cnt_nxt  = cnt_r + FIFO_CNT_W'(res_valid) - FIFO_CNT_W'(out_xfer);
    cred_nxt = cred_r + FIFO_CNT_W'(eff && out_due) - FIFO_CNT_W'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      cred_r   <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      cnt_r  <= cnt_nxt;
      cred_r <= cred_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

  // ------------------------------------------------------------ assertions
  a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cred_r)
    else $error("result queue holds more than the outstanding credits");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("credit count exceeds queue depth");

  a_frame_end_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_row_last)
    else $error("frame end without row end");

  a_no_forward_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wb_valid_r |-> $past(s1_r.valid && s1_r.pix))
    else $error("line store write without a pixel transfer");

endmodule

// ----- sim/image_convolution_3x3_unit_tb.sv -----
// ----------------------------------------------------------------------------
// image_convolution_3x3_unit_tb: self-checking bench for the 3x3 convolution
// Streams raster frames of many sizes and kernels through the unit. A
// behavioral model of the window, border clamping and Q4.12 round/clip
// predicts every result, and each out transfer is checked field by field.
// Both handshakes idle at random; one phase fills the unit under a long
// output hold-off.
// ----------------------------------------------------------------------------
module image_convolution_3x3_unit_tb;
  import icv_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int RANDOM_ITEMS = 700;
  localparam int SETTLE       = 10;
  localparam int LONG_HOLD    = 64;
  localparam int QUIET_LIMIT  = 1000;
  localparam int REPORT_CAP   = 40;
  localparam logic CMD_PIXEL  = ~CMD_DRAIN;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_cmd;
  pixel_t in_pixel_in;
  logic out_valid;
  logic out_stall;
  pixel_t out_pixel_out;
  logic out_row_last;
  logic out_frame_last;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  image_convolution_3x3_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_row_last  (out_row_last),
    .out_frame_last(out_frame_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [CFG_DATA_W-1:0] kernel_rows [3];
  pixel_t line_rows [3][MAX_W];
  int in_col, in_row, out_col, out_row;

  out_item_t expected_pixels [$];
  int unsigned accepted_items;
  int mismatches;
  bit idle_on;
  bit hold_off_req;

  function automatic int eff_size(input logic [10:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int kernel_at(input int idx);
    logic [CFG_DATA_W-1:0] r;
    r = kernel_rows[idx / 3];
    return int'($signed(r[COEF_W*(idx % 3) +: COEF_W]));
  endfunction

  function automatic int clamp_coord(input int c, input int size);
    if (c < 0) return 0;
    if (c >= size) return size - 1;
    return c;
  endfunction

  function automatic void restart_position();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void reset_model();
    width_reg = 11'(SIZE_RESET);
    height_reg = 11'(SIZE_RESET);
    kernel_rows[0] = COEF_TOP_RESET;
    kernel_rows[1] = COEF_MID_RESET;
    kernel_rows[2] = COEF_BOT_RESET;
    foreach (line_rows[r, c]) line_rows[r][c] = '0;
    restart_position();
  endfunction

  function automatic void model_reg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = v[10:0];
        restart_position();
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = v[10:0];
        restart_position();
      end
      REG_COEF_TOP: kernel_rows[0] = v;
      REG_COEF_MID: kernel_rows[1] = v;
      REG_COEF_BOTTOM: kernel_rows[2] = v;
      default: ;
    endcase
  endfunction

  // one accepted item in, at most one filtered pixel out
  function automatic bit conv_predict(input logic cmd, input pixel_t px, output out_item_t res);
    int w, h, t, dx, dy, cx, cy, sum, q;
    bit have_px, row_end, frame_end;
    pixel_t p;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    t = in_row * w + in_col;
    have_px = 1'b0;
    res = '0;
    if (t < w * h) begin
      if (cmd == CMD_DRAIN) return 1'b0;  // drain before the frame is complete
      have_px = 1'b1;
    end
    accepted_items++;
    if (t >= w + 1) begin
      sum = 0;
      for (dy = 0; dy < 3; dy++) begin
        cy = clamp_coord(out_row + dy - 1, h);
        for (dx = 0; dx < 3; dx++) begin
          cx = clamp_coord(out_col + dx - 1, w);
          // the pixel arriving with this item is not in the line store yet
          if (have_px && (cy * w + cx == t)) p = px;
          else p = line_rows[cy % 3][cx];
          sum += int'(p) * kernel_at((2 - dy) * 3 + (2 - dx));
        end
      end
      sum += ROUND_HALF;
      if (sum < 0) q = 0;
      else begin
        q = sum >>> FRAC_BITS;
        if (q > 255) q = 255;
      end
      row_end = (out_col == w - 1);
      frame_end = row_end && (out_row == h - 1);
      res.pixel = pixel_t'(q);
      res.row_last = row_end;
      res.frame_last = frame_end;
      if (frame_end) begin
        restart_position();
        return 1'b1;
      end
      if (row_end) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end
    if (have_px) line_rows[in_row % 3][in_col] = px;
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    return (t >= w + 1);  // a result is due once a row and a pixel are in
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < REPORT_CAP)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result, pixel_out", out_pixel_out, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_out !== want.pixel)
          report_mismatch("pixel_out", out_pixel_out, want.pixel);
        if (out_row_last !== want.row_last)
          report_mismatch("row_last", out_row_last, want.row_last);
        if (out_frame_last !== want.frame_last)
          report_mismatch("frame_last", out_frame_last, want.frame_last);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("image_convolution_3x3_unit_tb: FAIL");
        $finish;
      end
    end
  end

  // receiver: random stall before each transfer, or one long hold-off on request
  initial begin : out_stall_gen
    int hold;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold = LONG_HOLD;
        hold_off_req = 1'b0;
      end else begin
        hold = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic pixel_t rand_pixel();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(0, 6144) - 2048);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_kernel_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  task automatic send_item(input logic cmd, input pixel_t px);
    int gap;
    out_item_t res;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_pixel_in <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (conv_predict(cmd, px, res)) expected_pixels.push_back(res);
  endtask

  // sender holds off until every expected result is out and the pipe is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // leaves cfg_wr_en high; the caller lowers it after its last write
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    model_reg_write(idx, v);
  endtask

  // size writes carry junk above bit 10, which the unit must drop
  function automatic logic [CFG_DATA_W-1:0] size_word(input logic [10:0] v);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'({$urandom, $urandom});
    word[10:0] = v;
    return word;
  endfunction

  task automatic program_unit(input logic [10:0] w, input logic [10:0] h,
                              input logic [CFG_DATA_W-1:0] top,
                              input logic [CFG_DATA_W-1:0] mid,
                              input logic [CFG_DATA_W-1:0] bot);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, size_word(w));
    write_reg(REG_IMAGE_HEIGHT, size_word(h));
    write_reg(REG_COEF_TOP, top);
    write_reg(REG_COEF_MID, mid);
    write_reg(REG_COEF_BOTTOM, bot);
    cfg_wr_en <= 1'b0;
  endtask

  // pixels of the current frame up to cut, then the drain if the frame is
  // complete; the sender waits for the pipe to empty before pixel pause_at
  task automatic stream_frame(input int cut, input int pause_at);
    int w, n, i;
    w = eff_size(width_reg, MAX_W);
    n = w * eff_size(height_reg, MAX_H);
    for (i = 0; i < n && i < cut; i++) begin
      if (i == pause_at) wait_drained();
      if ($urandom_range(0, 15) == 0) send_item(CMD_DRAIN, rand_pixel());
      send_item(CMD_PIXEL, rand_pixel());
    end
    if (cut < n) return;
    for (i = 0; i <= w; i++)
      send_item(($urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_DRAIN, rand_pixel());
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_kernel();
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, size_word(11'd3));
    write_reg(REG_IMAGE_HEIGHT, size_word(11'd2));
    cfg_wr_en <= 1'b0;
    stream_frame(6, 6);
  endtask

  task automatic test_single_pixel_frame();
    program_unit(11'd1, 11'd1, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    send_item(CMD_DRAIN, 8'hFF);   // early drain, no effect
    send_item(CMD_PIXEL, 8'h5A);
    send_item(CMD_PIXEL, 8'hC3);   // frame full: taken as drain, pixel dropped
    send_item(CMD_DRAIN, 8'h00);
  endtask

  task automatic test_saturation();
    program_unit(11'd2, 11'd2, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    stream_frame(4, 4);
    program_unit(11'd2, 11'd2, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    stream_frame(4, 4);
  endtask

  // zero width and oversize height: one 1024-pixel column
  task automatic test_tallest_column();
    program_unit(11'd0, 11'd2047, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    stream_frame(MAX_H, MAX_H);
  endtask

  task automatic test_size_restart();
    program_unit(11'd6, 11'd4, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    stream_frame(10, 24);
    wait_drained();
    write_reg(REG_IMAGE_HEIGHT, size_word(11'd3));
    cfg_wr_en <= 1'b0;
    stream_frame(18, 18);
  endtask

  task automatic test_backpressure();
    program_unit(11'd8, 11'd6, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    idle_on = 1'b0;
    hold_off_req = 1'b1;
    stream_frame(48, 30);
    idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned goal;
    int n;
    logic [10:0] w, h;
    goal = accepted_items + RANDOM_ITEMS;
    while (accepted_items < goal) begin
      idle_on = ($urandom_range(0, 4) != 0);
      w = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 12));
      h = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
      program_unit(w, h, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
      n = eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H);
      stream_frame(($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n,
                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : n);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_PIXEL;
    in_pixel_in = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    accepted_items = 0;
    mismatches = 0;
    idle_on = 1'b1;
    hold_off_req = 1'b0;
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_kernel();
    test_single_pixel_frame();
    test_saturation();
    test_size_restart();
    test_backpressure();
    test_tallest_column();
    test_random_frames();

    wait_drained();
    if (mismatches == 0)
      $display("image_convolution_3x3_unit_tb: PASS");
    else
      $display("image_convolution_3x3_unit_tb: FAIL");
    $finish;
  end

endmodule
